[design/linear_probe_hash_table_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash table
// Checks are clocked on clk_i; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that is switched off while reset is asserted.
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that must also hold during reset.
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define LPHT_ASSERT(lbl, prop, msg)
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Field widths.
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned TAG_W  = 2;
  localparam int unsigned SLOT_W = TAG_W + KEY_W;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  // Slot tags.
  typedef enum logic [TAG_W-1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic take_in;
    logic mod_step;
    logic seek_home;
    logic advance;
    logic wr_live;
    logic wr_tomb;
    logic post;
    logic fail;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       walk_end;
    logic       tag_empty;
    logic       hit;
    logic       mod_done;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

[design/lpht_cmd_if.sv]
// ----------------------------------------------------------------------------
// lpht_cmd_if
// Command channel: one item is an operation code and a key.
// ----------------------------------------------------------------------------
interface lpht_cmd_if import lpht_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, command, key_value, input ready);
  modport sink   (input valid, command, key_value, output ready);

endinterface

[design/lpht_rsp_if.sv]
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: one item per command with status and counters.
// ----------------------------------------------------------------------------
interface lpht_rsp_if import lpht_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             status;
  logic [CNT_W-1:0] probe_count;
  logic [CNT_W-1:0] occupancy;

  modport source (output valid, status, probe_count, occupancy, input ready);
  modport sink   (input valid, status, probe_count, occupancy, output ready);

endinterface

[design/lpht_ctrl.sv]
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: clearing pass, item intake, home slot reduction and the
// probe walk decisions.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_c;
  logic       fail_c;
  logic       wr_live_c;
  logic       wr_tomb_c;
  logic       no_walk;

  // Full inserts and unknown codes finish without a walk.
  assign no_walk = ((sts_i.op == CMD_INSERT) && sts_i.full) ||
                   !(sts_i.op inside {CMD_INSERT, CMD_DELETE, CMD_FIND});

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    ctl_o     = '0;
    state_d   = state_q;
    done_c    = 1'b0;
    fail_c    = 1'b0;
    wr_live_c = 1'b0;
    wr_tomb_c = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.take_in = 1'b1;
          state_d       = ST_MOD;
        end
      end
      ST_MOD: begin
        if (no_walk) begin
          done_c = 1'b1;
          fail_c = 1'b1;
        end else if (!sts_i.mod_done) begin
          ctl_o.mod_step = 1'b1;
        end else begin
          ctl_o.seek_home = 1'b1;
          state_d         = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts_i.walk_end) begin
          done_c = 1'b1;
          fail_c = 1'b1;
        end else if (sts_i.op == CMD_INSERT) begin
          if (sts_i.tag_empty) begin
            done_c    = 1'b1;
            wr_live_c = 1'b1;
          end else begin
            ctl_o.advance = 1'b1;
          end
        end else if (sts_i.tag_empty) begin
          done_c = 1'b1;
          fail_c = 1'b1;
        end else if (sts_i.hit) begin
          done_c    = 1'b1;
          wr_tomb_c = (sts_i.op == CMD_DELETE);
        end else begin
          ctl_o.advance = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished item commits only once the output register can take it.
    if (done_c && sts_i.out_free) begin
      ctl_o.post    = 1'b1;
      ctl_o.fail    = fail_c;
      ctl_o.wr_live = wr_live_c;
      ctl_o.wr_tomb = wr_tomb_c;
      state_d       = ST_IDLE;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/lpht_dp.sv]
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: item registers, home slot reduction, probe index and count,
// slot memory, live counter and the output register.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  input  logic [1:0]       command_i,
  input  logic [KEY_W-1:0] key_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [CNT_W-1:0] probe_count_o,
  output logic [CNT_W-1:0] occupancy_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  logic [IW-1:0]     home;
  logic              mod_done;
  logic [IW-1:0]     idx_q, idx_d, idx_inc;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     live_q, live_d;
  logic [SLOT_W-1:0] mem [SLOTS];
  logic [SLOT_W-1:0] rd_q;
  logic [SLOT_W-1:0] wdata;
  logic              wr_en;
  tag_e              rd_tag;
  logic [KEY_W-1:0]  rd_key;
  logic              out_valid_q;
  logic              status_q;
  logic [CNT_W-1:0]  probe_q;
  logic [CNT_W-1:0]  occ_q;
  logic [31:0]       n_ext;
  logic [31:0]       live_ext;

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.take_in) begin
      op_q  <= command_i;
      key_q <= key_value_i;
    end
  end

  // Home slot: key modulo SLOTS.
  if (IS_POW2) begin : g_home_mask
    assign home     = key_q[IW-1:0];
    assign mod_done = 1'b1;
  end else begin : g_home_recip
    // Reciprocal of SLOTS scaled by 2^KEY_W.
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / SLOTS);
    logic [1:0]         step_q;
    logic [2*KEY_W-1:0] prod;
    logic [KEY_W-1:0]   quot_q;
    logic [KEY_W-1:0]   back;
    logic [KEY_W-1:0]   diff;
    logic [IW:0]        rem_q;

    // The quotient estimate is at most one low, so the first remainder is
    // below 2*SLOTS and one conditional subtract finishes the reduction.
    assign prod = (2*KEY_W)'(key_q) * (2*KEY_W)'(RECIP);
    assign back = quot_q * KEY_W'(SLOTS);
    assign diff = key_q - back;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= '0;
      end else if (ctl_i.take_in) begin
        step_q <= '0;
      end else if (ctl_i.mod_step) begin
        step_q <= step_q + 1'b1;
      end
    end

    // First step registers the quotient, second step the remainder.
    always_ff @(posedge clk_i) begin
      if (ctl_i.mod_step) begin
        if (step_q == '0) begin
          quot_q <= prod[2*KEY_W-1:KEY_W];
        end else begin
          rem_q <= diff[IW:0];
        end
      end
    end

    assign home     = (rem_q >= (IW+1)'(SLOTS)) ? IW'(rem_q - (IW+1)'(SLOTS))
                                                : rem_q[IW-1:0];
    assign mod_done = (step_q == 2'd2);
  end

  // Probe index and probe count.
  assign idx_inc = (idx_q == IW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

  always_comb begin
    idx_d = idx_q;
    n_d   = n_q;
    if (ctl_i.take_in) begin
      n_d = '0;
    end
    if (ctl_i.seek_home) begin
      idx_d = home;
    end else if (ctl_i.clr_wr || ctl_i.advance) begin
      idx_d = idx_inc;
    end
    if (ctl_i.advance) begin
      n_d = n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      n_q   <= '0;
    end else begin
      idx_q <= idx_d;
      n_q   <= n_d;
    end
  end

  // Slot memory: one write at the current index, registered read of the next.
  assign wr_en = ctl_i.clr_wr || ctl_i.wr_live || ctl_i.wr_tomb;

  always_comb begin
    if (ctl_i.wr_live) begin
      wdata = {TAG_LIVE, key_q};
    end else if (ctl_i.wr_tomb) begin
      wdata = {TAG_TOMB, {KEY_W{1'b0}}};
    end else begin
      wdata = {TAG_EMPTY, {KEY_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= wdata;
    end
    rd_q <= mem[idx_d];
  end

  assign rd_tag = tag_e'(rd_q[SLOT_W-1:KEY_W]);
  assign rd_key = rd_q[KEY_W-1:0];

  // Live key counter.
  always_comb begin
    live_d = live_q;
    if (ctl_i.wr_live) begin
      live_d = live_q + 1'b1;
    end else if (ctl_i.wr_tomb && (live_q != '0)) begin
      live_d = live_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= live_d;
    end
  end

  // Output register; counters are reported modulo 2^CNT_W.
  assign n_ext    = 32'(n_q);
  assign live_ext = 32'(live_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.post) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.post) begin
      status_q <= ctl_i.fail;
      probe_q  <= n_ext[CNT_W-1:0];
      occ_q    <= live_ext[CNT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign probe_count_o = probe_q;
  assign occupancy_o   = occ_q;

  // Status toward the controller.
  assign sts_o.op        = op_q;
  assign sts_o.full      = (live_q == NW'(SLOTS));
  assign sts_o.walk_end  = (n_q == NW'(SLOTS));
  assign sts_o.tag_empty = (rd_tag == TAG_EMPTY);
  assign sts_o.hit       = (rd_tag == TAG_LIVE) && (rd_key == key_q);
  assign sts_o.mod_done  = mod_done;
  assign sts_o.clr_last  = (idx_q == IW'(SLOTS - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[design/linear_probe_hash_table_top.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressed hash set with linear probing and tombstones.
//
//   Port    Direction  Item contents
//   cmd_i   in         command, key_value
//   rsp_o   out        status, probe_count, occupancy
//
// One item is taken at a time. With a power-of-two SLOTS an item occupies
// the block for intake, home slot and one slot read per probe; a refused
// insert or an unknown code finishes after intake without a walk. Other sizes
// add the reciprocal home slot reduction (quotient, then remainder).
// The slot memory's single read port sets one probe per cycle.
// After reset a clearing pass over every slot runs before the first item.
// A result waiting in the output register does not block the next intake;
// the walk holds at its last slot until that register is free.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_top_macros.svh"

module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpht_cmd_if.sink    cmd_i,
  lpht_rsp_if.source  rsp_o
);

  ctl_t ctl;
  sts_t sts;

  // Controller.
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath.
  lpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (cmd_i.command),
    .key_value_i   (cmd_i.key_value),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .probe_count_o (rsp_o.probe_count),
    .occupancy_o   (rsp_o.occupancy)
  );

  // After an item is taken the block is busy with it.
  `LPHT_ASSERT(a_busy_after_take, (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready, "intake while busy")
  // A key is only written into an empty slot inside the walk.
  `LPHT_ASSERT_ALWAYS(a_live_into_empty, ctl.wr_live |-> (sts.tag_empty && !sts.walk_end), "bad insert slot")
  // A tombstone only replaces the matching live slot.
  `LPHT_ASSERT_ALWAYS(a_tomb_on_hit, ctl.wr_tomb |-> sts.hit, "tombstone without match")
  // A result is never posted over one that is still waiting.
  `LPHT_ASSERT_ALWAYS(a_post_when_free, ctl.post |-> sts.out_free, "result overwritten")

endmodule

[sim/lpht_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpht_result_checker
// Watches the command and response channels of the linear probing hash
// table. It keeps its own copy of the slot array and the live key count,
// works out the response of every accepted command, and compares every
// accepted response with the oldest one still owed.
// ----------------------------------------------------------------------------
module lpht_result_checker import lpht_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  lpht_cmd_if  cmd_mon_i,
  lpht_rsp_if  rsp_mon_i,
  output int   mismatch_count_o,
  output int   outstanding_o
);

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] probe_count;
    logic [CNT_W-1:0] occupancy;
  } response_t;

  // Shadow copy of the table.
  tag_e             slot_tag [SLOTS];
  logic [KEY_W-1:0] slot_key [SLOTS];
  int unsigned      live_keys;

  // Responses owed by the block, oldest first.
  response_t        owed_rsp [$];
  int               mismatch_count;

  // Applies one command to the shadow table and returns its response.
  function automatic response_t apply_command(input logic [1:0]       op,
                                              input logic [KEY_W-1:0] key);
    int unsigned idx;
    int unsigned steps;
    bit          hit;
    response_t   rsp;
    rsp.status = 1'b1;
    steps      = 0;
    hit        = 1'b0;
    idx        = key % SLOTS;
    case (op)
      CMD_INSERT: begin
        // A full table is refused before any slot is read.
        if (live_keys < SLOTS) begin
          while (steps < SLOTS && slot_tag[idx] != TAG_EMPTY) begin
            idx = (idx + 1) % SLOTS;
            steps++;
          end
          if (steps < SLOTS) begin
            slot_tag[idx] = TAG_LIVE;
            slot_key[idx] = key;
            live_keys++;
            rsp.status = 1'b0;
          end
        end
      end
      CMD_DELETE, CMD_FIND: begin
        // Walk over tombstones and other keys until a match or an empty slot.
        while (steps < SLOTS && slot_tag[idx] != TAG_EMPTY && !hit) begin
          if (slot_tag[idx] == TAG_LIVE && slot_key[idx] == key) begin
            hit = 1'b1;
          end else begin
            idx = (idx + 1) % SLOTS;
            steps++;
          end
        end
        if (hit) begin
          rsp.status = 1'b0;
          if (op == CMD_DELETE) begin
            slot_tag[idx] = TAG_TOMB;
            live_keys--;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.probe_count = steps[CNT_W-1:0];
    rsp.occupancy   = live_keys[CNT_W-1:0];
    return rsp;
  endfunction

  // Reports one bad response; only the first few are printed.
  function automatic void log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: response mismatch: %s", $realtime, what);
    end
  endfunction

  // Compare responses, then predict the command taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    response_t want;
    if (!rst_ni) begin
      foreach (slot_tag[i]) begin
        slot_tag[i] = TAG_EMPTY;
        slot_key[i] = '0;
      end
      live_keys = 0;
      owed_rsp.delete();
      mismatch_count   = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (owed_rsp.size() == 0) begin
          log_mismatch($sformatf("item with none owed: status %0d probes %0d occupancy %0d",
                                 rsp_mon_i.status, rsp_mon_i.probe_count,
                                 rsp_mon_i.occupancy));
        end else begin
          want = owed_rsp.pop_front();
          if (rsp_mon_i.status !== want.status ||
              rsp_mon_i.probe_count !== want.probe_count ||
              rsp_mon_i.occupancy !== want.occupancy) begin
            log_mismatch($sformatf({"expected status %0d probes %0d occupancy %0d, ",
                                    "got status %0d probes %0d occupancy %0d"},
                                   want.status, want.probe_count, want.occupancy,
                                   rsp_mon_i.status, rsp_mon_i.probe_count,
                                   rsp_mon_i.occupancy));
          end
        end
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        owed_rsp.push_back(apply_command(cmd_mon_i.command, cmd_mon_i.key_value));
      end
      mismatch_count_o <= mismatch_count;
      outstanding_o    <= owed_rsp.size();
    end
  end

endmodule

[sim/linear_probe_hash_table_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_test
// Drives the hash table through its whole life: a few directed commands on
// an empty table, then random inserts and lookups until every slot is
// taken, then deletes, lookups and refused inserts on a table with no empty
// slot left. The sender works in bursts and the receiver stalls on its own
// pattern; the checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_test;
  import lpht_pkg::*;

  localparam int unsigned      TABLE_SLOTS  = 1024;
  localparam logic [KEY_W-1:0] MAX_KEY      = '1;
  localparam logic [KEY_W-1:0] LAST_HOME    = KEY_W'(TABLE_SLOTS - 1);
  localparam logic [1:0]       CMD_UNKNOWN  = 2'd3;
  localparam int unsigned      DRAIN_CYCLES = TABLE_SLOTS + 64;
  localparam int unsigned      RUN_LIMIT_NS = 40_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lpht_cmd_if cmd_bus ();
  lpht_rsp_if rsp_bus ();

  int               mismatches;
  int               outstanding;
  int unsigned      burst_left;
  int unsigned      inserts_done;
  logic [KEY_W-1:0] stored_keys [$];

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  linear_probe_hash_table_top #(
    .SLOTS (TABLE_SLOTS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  lpht_result_checker #(
    .SLOTS (TABLE_SLOTS)
  ) checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cmd_mon_i        (cmd_bus),
    .rsp_mon_i        (rsp_bus),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  function automatic logic [KEY_W-1:0] any_key();
    logic [KEY_W-1:0] key;
    key = KEY_W'($urandom);
    return key;
  endfunction

  // A key known to be live in the table, or any key while none is stored.
  function automatic logic [KEY_W-1:0] pick_stored();
    if (stored_keys.size() == 0) begin
      return any_key();
    end
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Sends one item in the current burst and tracks which keys are live.
  task automatic send_command(input logic [1:0] op, input logic [KEY_W-1:0] key);
    int unsigned gap;
    int unsigned idx;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd_bus.valid     <= 1'b1;
    cmd_bus.command   <= op;
    cmd_bus.key_value <= key;
    do @(posedge clk); while (!cmd_bus.ready);
    // Inserts succeed until the table has been filled once.
    if (op == CMD_INSERT && inserts_done < TABLE_SLOTS) begin
      stored_keys.push_back(key);
      inserts_done++;
    end
    // A delete of a live key removes one copy of it.
    if (op == CMD_DELETE) begin
      idx = 0;
      while (idx < stored_keys.size() && stored_keys[idx] != key) idx++;
      if (idx < stored_keys.size()) begin
        stored_keys.delete(idx);
      end
    end
  endtask

  // Holds the sender off until every owed response has come back.
  task automatic wait_for_drain();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    burst_left = 0;
  endtask

  // Receiver: always ready, light random stalls, long stalls, heavy stalls.
  initial begin : rsp_pacing
    int unsigned cycle_cnt;
    int unsigned stall_left;
    cycle_cnt  = 0;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      case ((cycle_cnt >> 8) % 4)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        2: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 24);
            rsp_bus.ready <= 1'b0;
          end else begin
            rsp_bus.ready <= 1'b1;
          end
        end
        default: rsp_bus.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned      pick;
    int unsigned      items;
    int unsigned      waited;
    int unsigned      home;
    logic [KEY_W-1:0] key;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.command   <= CMD_INSERT;
    cmd_bus.key_value <= '0;
    burst_left   = 0;
    inserts_done = 0;
    items        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: misses stop at once, unknown command changes nothing.
    send_command(CMD_FIND, '0);
    send_command(CMD_DELETE, MAX_KEY);
    send_command(CMD_UNKNOWN, 31'h5555_5555);
    // Extreme keys and a chain that wraps past the last slot.
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, MAX_KEY);
    send_command(CMD_INSERT, LAST_HOME);
    send_command(CMD_INSERT, KEY_W'(2 * TABLE_SLOTS - 1));
    send_command(CMD_INSERT, KEY_W'(TABLE_SLOTS));
    send_command(CMD_INSERT, '0);
    send_command(CMD_FIND, KEY_W'(2 * TABLE_SLOTS - 1));
    send_command(CMD_FIND, '0);
    send_command(CMD_FIND, KEY_W'(3 * TABLE_SLOTS - 1));
    send_command(CMD_FIND, 5);
    send_command(CMD_DELETE, KEY_W'(3 * TABLE_SLOTS - 1));
    send_command(CMD_UNKNOWN, '0);
    send_command(CMD_FIND, 31'h2AAA_AAAA);
    send_command(CMD_INSERT, 31'h2AAA_AAAA);
    send_command(CMD_INSERT, 31'h5555_5555);
    wait_for_drain();

    // Fill every slot; lookups hit and miss along growing clusters.
    while (inserts_done < TABLE_SLOTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_command(CMD_INSERT, any_key());
      end else if (pick < 76) begin
        // Keys whose home slots crowd around the wrap point.
        home = (TABLE_SLOTS - 8 + $urandom_range(0, 15)) % TABLE_SLOTS;
        key  = KEY_W'($urandom_range(0, MAX_KEY / TABLE_SLOTS - 1) * TABLE_SLOTS + home);
        send_command(CMD_INSERT, key);
      end else if (pick < 88) begin
        send_command(CMD_INSERT, pick_stored());
      end else if (pick < 94) begin
        send_command(CMD_FIND, pick_stored());
      end else if (pick < 98) begin
        send_command(CMD_FIND, any_key());
      end else begin
        send_command(CMD_UNKNOWN, any_key());
      end
      items++;
      if (items % 300 == 0) begin
        wait_for_drain();
      end
    end

    // Table full: inserts are refused without a walk.
    send_command(CMD_INSERT, any_key());
    send_command(CMD_INSERT, '0);
    wait_for_drain();

    // Tombstones: a lookup passes them, a refused insert finds no empty slot.
    send_command(CMD_DELETE, '0);
    send_command(CMD_FIND, '0);
    send_command(CMD_DELETE, '0);
    send_command(CMD_FIND, '0);
    send_command(CMD_INSERT, 7);
    send_command(CMD_DELETE, MAX_KEY);
    send_command(CMD_FIND, LAST_HOME);

    // No empty slot left: deletes and lookups on a thinning table.
    repeat (110) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_command(CMD_DELETE, pick_stored());
      end else if (pick < 55) begin
        send_command(CMD_DELETE, any_key());
      end else if (pick < 80) begin
        send_command(CMD_FIND, pick_stored());
      end else if (pick < 88) begin
        send_command(CMD_FIND, any_key());
      end else if (pick < 96) begin
        send_command(CMD_INSERT, any_key());
      end else begin
        send_command(CMD_UNKNOWN, any_key());
      end
      items++;
      if (items % 300 == 0) begin
        wait_for_drain();
      end
    end

    // Let the last responses come home, then give the verdict.
    cmd_bus.valid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < 4 * DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (outstanding != 0) begin
      $display("linear_probe_hash_table_top_test: FAIL");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatches == 0 && outstanding == 0) begin
        $display("linear_probe_hash_table_top_test: PASS");
      end else begin
        $display("linear_probe_hash_table_top_test: FAIL");
      end
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("linear_probe_hash_table_top_test: FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/lpht_pkg.sv
design/lpht_cmd_if.sv
design/lpht_rsp_if.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probe_hash_table_top.sv
sim/lpht_result_checker.sv
sim/linear_probe_hash_table_top_test.sv
